[design/ttf_pkg.sv]
// Shared types and status codes for the TLV type finder.
`default_nettype none

package ttf_pkg;

    localparam int TYPE_W = 15;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_TRUNC_HDR = 3'd2;
    localparam logic [2:0] ST_TRUNC_VAL = 3'd3;
    localparam logic [2:0] ST_MANDATORY = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tlv_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] value_offset;
        logic [15:0] value_length;
    } tlv_out_t;

endpackage

`default_nettype wire

[design/ttf_parse.sv]
// Per-byte TLV parse state and its registered update.
`default_nettype none

module ttf_parse
    import ttf_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire tlv_in_t           item,
    input  wire logic [TYPE_W-1:0] match_type,
    output tlv_out_t               result
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_FAILED = 2'd2;

    logic [1:0]             phase_reg,    phase_next;
    logic [1:0]             count_reg,    count_next;
    logic [23:0]            shift_reg,    shift_next;
    logic [15:0]            remain_reg,   remain_next;
    logic [LENGTH_BITS-1:0] pos_reg,      pos_next;
    logic                   matches_reg,  matches_next;
    logic                   optional_reg, optional_next;
    logic [15:0]            vstart_reg,   vstart_next;
    logic [15:0]            plen_reg,     plen_next;
    logic                   found_reg,    found_next;
    logic [15:0]            foffs_reg,    foffs_next;
    logic [15:0]            flen_reg,     flen_next;
    logic [2:0]             err_reg,      err_next;

    logic [LENGTH_BITS-1:0] pos_inc;
    logic [31:0]            header;
    logic                   fin;
    logic                   fin_match;
    logic                   fin_opt;
    logic [15:0]            fin_start;
    logic [15:0]            fin_len;

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        remain_next   = remain_reg;
        pos_next      = pos_reg;
        matches_next  = matches_reg;
        optional_next = optional_reg;
        vstart_next   = vstart_reg;
        plen_next     = plen_reg;
        found_next    = found_reg;
        foffs_next    = foffs_reg;
        flen_next     = flen_reg;
        err_next      = err_reg;
        result        = '0;

        pos_inc   = pos_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        header    = {shift_reg, item.data_byte};
        fin       = 1'b0;
        fin_match = matches_reg;
        fin_opt   = optional_reg;
        fin_start = vstart_reg;
        fin_len   = plen_reg;

        if (step && phase_reg != PH_FAILED)
        begin
            if (pos_reg == '1)
            begin
                // The counter is saturated: this byte is not parsed.
                phase_next = PH_FAILED;
                err_next   = ST_TOO_LONG;
            end
            else
            begin
                pos_next = pos_inc;
                case (phase_reg)
                    PH_HEADER:
                    begin
                        shift_next = header[23:0];
                        if (count_reg != 2'd3)
                        begin
                            count_next = count_reg + 2'd1;
                        end
                        else
                        begin
                            count_next    = 2'd0;
                            fin_match     = (header[30:16] == match_type);
                            fin_opt       = header[31];
                            fin_start     = 16'(pos_inc);
                            fin_len       = header[15:0];
                            matches_next  = fin_match;
                            optional_next = fin_opt;
                            vstart_next   = fin_start;
                            plen_next     = fin_len;
                            if (header[15:0] == 16'd0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                remain_next = header[15:0];
                                phase_next  = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        remain_next = remain_reg - 16'd1;
                        fin         = (remain_next == 16'd0);
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                if (fin)
                begin
                    if (fin_match)
                    begin
                        phase_next = PH_HEADER;
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            foffs_next = fin_start;
                            flen_next  = fin_len;
                        end
                    end
                    else if (!fin_opt)
                    begin
                        phase_next = PH_FAILED;
                        err_next   = ST_MANDATORY;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
            end
        end

        if (step && item.last_byte)
        begin
            if (phase_next == PH_FAILED)
                result.status = err_next;
            else if (phase_next == PH_VALUE)
                result.status = ST_TRUNC_VAL;
            else if (count_next != 2'd0)
                result.status = ST_TRUNC_HDR;
            else if (found_next)
                result.status = ST_FOUND;
            else
                result.status = ST_NOT_FOUND;

            if (result.status == ST_FOUND)
            begin
                result.value_offset = foffs_next;
                result.value_length = flen_next;
            end

            // The payload is done; start the next one from a clean state.
            phase_next    = PH_HEADER;
            count_next    = 2'd0;
            shift_next    = '0;
            remain_next   = '0;
            pos_next      = '0;
            matches_next  = 1'b0;
            optional_next = 1'b0;
            vstart_next   = '0;
            plen_next     = '0;
            found_next    = 1'b0;
            foffs_next    = '0;
            flen_next     = '0;
            err_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            count_reg    <= 2'd0;
            shift_reg    <= '0;
            remain_reg   <= '0;
            pos_reg      <= '0;
            matches_reg  <= 1'b0;
            optional_reg <= 1'b0;
            vstart_reg   <= '0;
            plen_reg     <= '0;
            found_reg    <= 1'b0;
            foffs_reg    <= '0;
            flen_reg     <= '0;
            err_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
            remain_reg   <= remain_next;
            pos_reg      <= pos_next;
            matches_reg  <= matches_next;
            optional_reg <= optional_next;
            vstart_reg   <= vstart_next;
            plen_reg     <= plen_next;
            found_reg    <= found_next;
            foffs_reg    <= foffs_next;
            flen_reg     <= flen_next;
            err_reg      <= err_next;
        end
    end

endmodule

`default_nettype wire

[design/tlv_type_finder.sv]
// A byte is registered on its transfer and parsed from that register; a result is
// registered into the output register when the last byte is parsed.
// Throughput: one byte per cycle unless stalled, set by the parse state update.
// The whole block stalls only while a result waits on a stalled output.
// Reset clears the parse state, the pipeline valids and the searched type to zero.
`default_nettype none

module tlv_type_finder
    import ttf_pkg::*;
#(
    parameter int LENGTH_BITS = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tlv_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tlv_out_t               out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [TYPE_W-1:0] cfg_data
);

    logic              in_valid_reg;
    tlv_in_t           in_item_reg;
    logic              out_valid_reg;
    tlv_out_t          out_data_reg;
    logic [TYPE_W-1:0] wanted_reg;
    logic              advance;
    tlv_out_t          parse_result;

    // The pipeline moves whenever the output slot is empty or being taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ttf_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_valid_reg && advance),
        .item        (in_item_reg),
        .match_type  (wanted_reg),
        .result      (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wanted_reg    <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg && in_item_reg.last_byte;
            if (cfg_valid && cfg_ready)
                wanted_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
        if (advance && in_valid_reg && in_item_reg.last_byte)
            out_data_reg <= parse_result;
    end

`ifndef SYNTHESIS
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(in_valid_reg && in_item_reg.last_byte))
        else $error("result appeared without a last byte");

    a_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_FOUND)
            |-> (out_data.value_offset == 16'd0 && out_data.value_length == 16'd0))
        else $error("offset or length set on a failed search");
`endif

endmodule

`default_nettype wire
